[design/utg_pkg.sv]
// shared types, constants and helpers for the utf-8 to gb2312 transcoder
// no dependencies

package utg_pkg;

  localparam logic       REQ_LOAD        = 1'b0;
  localparam logic       REQ_TEXT        = 1'b1;
  localparam logic [7:0] CONT_MASK       = 8'h3F;
  localparam logic [13:0] ENTRY_COUNT_RST = 14'd8192;

  typedef struct packed {
    logic        start;
    logic [15:0] key;
    logic [13:0] count;
  } lkup_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] gb;
  } lkup_rsp_t;

  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

[design/utg_lookup.sv]
// conversion table memory and binary search engine
// depends on utg_pkg

module utg_lookup import utg_pkg::*; #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_we_i,
  input  logic [12:0] load_idx_i,
  input  logic [31:0] load_data_i,
  input  lkup_req_t   req_i,
  output lkup_rsp_t   rsp_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BW = AW + 1;

  typedef enum logic [1:0] {
    L_IDLE,
    L_SRCH,
    L_MISS
  } lk_state_e;

  lk_state_e     state_q;
  logic [31:0]   mem [TABLE_DEPTH];
  logic [31:0]   rd_data_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] mid_q;
  logic [BW-1:0] lo_q, hi_q, lo_d, hi_d;
  logic [15:0]   key_q;
  logic [BW-1:0] lim;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          hit;
  logic          go_miss;
  lkup_rsp_t     rsp_q;

  function automatic logic [AW-1:0] mid_of(input logic [BW-1:0] lo, input logic [BW-1:0] hi);
    logic [BW:0] s;
    s = {1'b0, lo} + {1'b0, hi} - (BW+1)'(1);
    return AW'(s >> 1);
  endfunction

  assign lim     = (32'(req_i.count) > 32'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : BW'(req_i.count);
  assign wr_en   = load_we_i && (32'(load_idx_i) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(32'(load_idx_i));

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    rd_addr = '0;
    hit     = 1'b0;
    go_miss = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        lo_d = '0;
        hi_d = lim;
        if (lim != '0) begin
          rd_addr = mid_of('0, lim);
        end
      end
      L_SRCH: begin
        if (key_q < rd_data_q[31:16]) begin
          hi_d = BW'(mid_q);
        end else if (key_q > rd_data_q[31:16]) begin
          lo_d = BW'(mid_q) + BW'(1);
        end else begin
          hit = 1'b1;
        end
        if (!hit) begin
          if (lo_d < hi_d) begin
            rd_addr = mid_of(lo_d, hi_d);
          end else begin
            go_miss = 1'b1;
          end
        end
      end
      L_MISS: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= load_data_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    mid_q <= rd_addr;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    if (state_q == L_IDLE && req_i.start) begin
      key_q <= req_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      rsp_q   <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            state_q <= (lim != '0) ? L_SRCH : L_MISS;
          end
        end
        L_SRCH: begin
          if (hit) begin
            rsp_q.done <= 1'b1;
            rsp_q.gb   <= rd_data_q[15:0];
            state_q    <= L_IDLE;
          end else if (go_miss) begin
            state_q <= L_MISS;
          end
        end
        L_MISS: begin
          rsp_q.done <= 1'b1;
          rsp_q.gb   <= rd_data_q[15:0];
          state_q    <= L_IDLE;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule

[design/utf8_to_gb2312_transcoder.sv]
// top level: utf-8 decode, table load, result queue and config register
// depends on utg_pkg and utg_lookup
//
//  channel  dir  handshake                  payload
//  in       in   in_valid_i / in_ready_o    req_type, entry_index, entry_unicode,
//                                           entry_gb, text_byte, end_of_string
//  out      out  out_valid_o / out_ready_i  out_byte, last_of_char
//  cfg      in   cfg_we_i                   cfg_wdata_i (entry_count)
//
// load and single-byte or non-final text requests are handled as they are accepted. the final
// byte of a multibyte character starts a binary search in the table memory: one
// compare per cycle, at most $clog2(TABLE_DEPTH)+1 compares, then a reread of entry 0
// on a miss, and both gb bytes are then queued together.
// input stalls from that byte until both gb bytes are queued, which needs an empty
// queue, and while the queue is full. no clearing after reset.

module utf8_to_gb2312_transcoder import utg_pkg::*; #(
  parameter int TABLE_DEPTH = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [12:0] entry_index_i,
  input  logic [15:0] entry_unicode_i,
  input  logic [15:0] entry_gb_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_char_o,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_EMIT
  } state_e;

  state_e      state_q;
  logic [13:0] entry_count_q;
  logic [2:0]  bytes_left_q;
  logic [15:0] accum_q;
  logic [15:0] gb_q;
  logic [1:0]  q_cnt_q, q_cnt_d;
  logic [7:0]  q_byte_q [2];
  logic        q_last_q [2];

  logic        acc;
  logic        is_text;
  logic [3:0]  n_ones;
  logic [7:0]  lead_bits;
  logic [15:0] accum_nxt;
  logic        push1;
  logic [7:0]  push1_byte;
  logic        push2;
  logic        pop;
  logic        pos1;
  lkup_req_t   lk_req;
  lkup_rsp_t   lk_rsp;

  assign in_ready_o = (state_q == S_IDLE) && (q_cnt_q != 2'd2);
  assign acc        = in_valid_i && in_ready_o;
  assign is_text    = (req_type_i == REQ_TEXT);
  assign n_ones     = lead_ones(text_byte_i);
  assign lead_bits  = text_byte_i & (8'hFF >> n_ones);
  assign accum_nxt  = {accum_q[9:0], text_byte_i[5:0] & CONT_MASK[5:0]};

  assign push1      = acc && is_text && (bytes_left_q == 3'd0) && (n_ones <= 4'd1);
  assign push1_byte = text_byte_i & 8'h7F;
  assign push2      = (state_q == S_EMIT) && (q_cnt_q == 2'd0);
  assign pop        = out_valid_o && out_ready_i;
  assign pos1       = (q_cnt_q == 2'd1) && !pop;

  assign lk_req.start = acc && is_text && (bytes_left_q == 3'd1);
  assign lk_req.key   = accum_nxt;
  assign lk_req.count = entry_count_q;

  utg_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_we_i  (acc && (req_type_i == REQ_LOAD)),
    .load_idx_i (entry_index_i),
    .load_data_i({entry_unicode_i, entry_gb_i}),
    .req_i      (lk_req),
    .rsp_o      (lk_rsp)
  );

  always_comb begin
    q_cnt_d = q_cnt_q - {1'b0, pop} + {1'b0, push1};
    if (push2) begin
      q_cnt_d = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      entry_count_q <= ENTRY_COUNT_RST;
      bytes_left_q  <= 3'd0;
      accum_q       <= 16'd0;
      q_cnt_q       <= 2'd0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc && is_text) begin
            if (bytes_left_q == 3'd0) begin
              if (n_ones > 4'd1) begin
                if (end_of_string_i) begin
                  bytes_left_q <= 3'd0;
                  accum_q      <= 16'd0;
                end else begin
                  bytes_left_q <= 3'(n_ones - 4'd1);
                  accum_q      <= {8'd0, lead_bits};
                end
              end
            end else if (bytes_left_q == 3'd1) begin
              bytes_left_q <= 3'd0;
              accum_q      <= 16'd0;
              state_q      <= S_WAIT;
            end else if (end_of_string_i) begin
              bytes_left_q <= 3'd0;
              accum_q      <= 16'd0;
            end else begin
              bytes_left_q <= bytes_left_q - 3'd1;
              accum_q      <= accum_nxt;
            end
          end
        end
        S_WAIT: begin
          if (lk_rsp.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (push2) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT && lk_rsp.done) begin
      gb_q <= lk_rsp.gb;
    end
    if (pop) begin
      q_byte_q[0] <= q_byte_q[1];
      q_last_q[0] <= q_last_q[1];
    end
    if (push1) begin
      if (pos1) begin
        q_byte_q[1] <= push1_byte;
        q_last_q[1] <= 1'b1;
      end else begin
        q_byte_q[0] <= push1_byte;
        q_last_q[0] <= 1'b1;
      end
    end
    if (push2) begin
      q_byte_q[0] <= gb_q[15:8];
      q_last_q[0] <= 1'b0;
      q_byte_q[1] <= gb_q[7:0];
      q_last_q[1] <= 1'b1;
    end
  end

  assign out_valid_o    = (q_cnt_q != 2'd0);
  assign out_byte_o     = q_byte_q[0];
  assign last_of_char_o = q_last_q[0];

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q != 2'd3)
    else $error("result queue overflow");

  a_rsp_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_rsp.done |-> state_q == S_WAIT)
    else $error("lookup response outside of wait state");

  a_full_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q == 2'd2 |-> q_last_q[1])
    else $error("queue tail does not close a character");

  a_emit_clears_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push2 |=> q_cnt_q == 2'd2 && !last_of_char_o)
    else $error("gb code not queued high byte first");
`endif

endmodule
